// ===== rtl/dtb_pkg.sv =====
`default_nettype none
package dtb_pkg;

	localparam int ACCUM_BITS = 64;
	localparam int PROD_W     = ACCUM_BITS + 4;
	localparam int NUMQ_DEPTH = 2;
	localparam int NUMQ_PTR_W = (NUMQ_DEPTH > 1) ? $clog2(NUMQ_DEPTH) : 1;
	localparam int NUMQ_CNT_W = $clog2(NUMQ_DEPTH + 1);
	localparam int MAX_BYTES  = 8;
	localparam int BYTE_IDX_W = 3;
	localparam int REG_IDX_W  = 1;

	localparam logic [7:0] DIGIT_LO   = 8'h2F;
	localparam logic [7:0] DIGIT_HI   = 8'h3A;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH_BYTES = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BIG_ENDIAN  = 1'b1;

	localparam logic [3:0] WIDTH_BYTES_RST = 4'd4;

	typedef logic [ACCUM_BITS-1:0] acc_t;

	typedef struct packed {
		logic [3:0] width_bytes;
		logic       big_endian;
	} cfg_t;

	typedef struct packed {
		logic push;
		acc_t value;
	} numq_wr_t;

	typedef struct packed {
		logic avail;
		acc_t value;
	} numq_rd_t;

endpackage
`default_nettype wire

// ===== rtl/dtb_front.sv =====
`default_nettype none
module dtb_front
	import dtb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic       full,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_stream,
	output numq_wr_t        numq_wr
);

	acc_t              acc_q;
	logic              have_q;
	logic              accept;
	logic              is_digit;
	logic [3:0]        digit;
	logic [PROD_W-1:0] prod;
	logic              sat;
	acc_t              acc_next;

	always_comb begin
		accept   = push && !full;
		is_digit = (text_byte > DIGIT_LO) && (text_byte < DIGIT_HI);
		digit    = 4'(text_byte - DIGIT_ZERO);
		// acc*10 + d; any carry past the top bit means saturate
		prod = (PROD_W'(acc_q) << 3) + (PROD_W'(acc_q) << 1) + PROD_W'(digit);
		sat  = |prod[PROD_W-1:ACCUM_BITS];
		acc_next = sat ? '1 : prod[ACCUM_BITS-1:0];
		numq_wr.push  = accept && have_q && (end_of_stream || !is_digit);
		numq_wr.value = acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			have_q <= 1'b0;
		end else if (accept) begin
			if (!end_of_stream && is_digit) begin
				acc_q  <= acc_next;
				have_q <= 1'b1;
			end else begin
				acc_q  <= '0;
				have_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dtb_numq.sv =====
`default_nettype none
module dtb_numq
	import dtb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire numq_wr_t numq_wr,
	input  wire logic     numq_pop,
	output numq_rd_t      numq_rd,
	output logic          full
);

	acc_t                  mem_q [NUMQ_DEPTH];
	logic [NUMQ_PTR_W-1:0] wr_ptr_q;
	logic [NUMQ_PTR_W-1:0] rd_ptr_q;
	logic [NUMQ_CNT_W-1:0] cnt_q;
	logic                  do_pop;

	always_comb begin
		full          = (cnt_q == NUMQ_CNT_W'(NUMQ_DEPTH));
		numq_rd.avail = (cnt_q != '0);
		numq_rd.value = mem_q[rd_ptr_q];
		do_pop        = numq_pop && numq_rd.avail;
	end

	always_ff @(posedge clk) begin
		if (numq_wr.push) begin
			mem_q[wr_ptr_q] <= numq_wr.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (numq_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == NUMQ_PTR_W'(NUMQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == NUMQ_PTR_W'(NUMQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (numq_wr.push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!numq_wr.push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dtb_back.sv =====
`default_nettype none
module dtb_back
	import dtb_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire numq_rd_t numq_rd,
	output logic          numq_pop,
	input  wire logic     pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          last_byte
);

	logic                  valid_q;
	logic [BYTE_IDX_W-1:0] k_q;
	logic [7:0]            byte_q;
	logic                  last_q;
	logic [BYTE_IDX_W-1:0] wm1;
	logic [BYTE_IDX_W-1:0] pos;
	logic [63:0]           ext;
	logic [7:0]            sel;
	logic                  adv;
	logic                  emit;
	logic                  is_last;

	always_comb begin
		priority if (cfg.width_bytes == 4'd0) begin
			wm1 = '0;
		end else if (cfg.width_bytes > 4'(MAX_BYTES)) begin
			wm1 = BYTE_IDX_W'(MAX_BYTES - 1);
		end else begin
			wm1 = BYTE_IDX_W'(cfg.width_bytes - 4'd1);
		end
		pos      = cfg.big_endian ? (wm1 - k_q) : k_q;
		ext      = 64'(numq_rd.value);
		sel      = ext[{pos, 3'b000} +: 8];
		is_last  = (k_q == wm1);
		adv      = !valid_q || pop;
		emit     = adv && numq_rd.avail;
		numq_pop = emit && is_last;
		empty     = !valid_q;
		out_byte  = byte_q;
		last_byte = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else if (emit) begin
			valid_q <= 1'b1;
			k_q     <= is_last ? '0 : k_q + 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= sel;
			last_q <= is_last;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/decimal_text_to_binary_core.sv =====
// A terminating byte (non-digit or end mark) writes the number into the queue,
// from which the back end registers its first byte onto out_byte when free.
// Throughput: one text byte per cycle in while full is low; the output side
// sends numbers back to back. A two-entry number queue decouples the two sides.
// Reset (arst_n low, async): no pending number, queue and output empty,
// width_bytes = 4, big_endian = 0.
`default_nettype none
module decimal_text_to_binary_core
	import dtb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [7:0]           text_byte,
	input  wire logic                 end_of_stream,
	output logic                      empty,
	input  wire logic                 pop,
	output logic [7:0]                out_byte,
	output logic                      last_byte,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [3:0]           wr_data
);

	cfg_t     cfg_q;
	numq_wr_t numq_wr;
	numq_rd_t numq_rd;
	logic     numq_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_bytes <= WIDTH_BYTES_RST;
			cfg_q.big_endian  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH_BYTES: cfg_q.width_bytes <= wr_data;
				REG_BIG_ENDIAN:  cfg_q.big_endian  <= wr_data[0];
			endcase
		end
	end

	dtb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.text_byte     (text_byte),
		.end_of_stream (end_of_stream),
		.numq_wr       (numq_wr)
	);

	dtb_numq u_numq (
		.clk      (clk),
		.arst_n   (arst_n),
		.numq_wr  (numq_wr),
		.numq_pop (numq_pop),
		.numq_rd  (numq_rd),
		.full     (full)
	);

	dtb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.numq_rd   (numq_rd),
		.numq_pop  (numq_pop),
		.pop       (pop),
		.empty     (empty),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
`default_nettype wire

// ===== rtl/dtb_checker.sv =====
`default_nettype none
module dtb_checker
	import dtb_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       full,
	input wire logic       empty,
	input wire logic       pop,
	input wire logic [7:0] out_byte,
	input wire logic       last_byte
);

	// held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(last_byte)))
		else $error("result word changed while stalled");

	// bytes of one number follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_byte) |=> !empty)
		else $error("gap inside a multi-byte number");

	a_rst_out: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result side not empty in reset");

	a_rst_in: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("input side full in reset");

endmodule

bind decimal_text_to_binary_core dtb_checker u_dtb_checker (.*);
`default_nettype wire
